// ===== rtl/mpq_pkg.sv =====
// Package with the shared types, codes and constants of the min-priority queue.
`default_nettype none

package mpq_pkg;

  localparam int DEFAULT_CAPACITY = 16;
  localparam int KEY_W            = 32;
  localparam int COUNT_OUT_W      = 5;

  // Request codes carried in the req_type field.
  localparam logic REQ_INSERT  = 1'b0;
  localparam logic REQ_EXTRACT = 1'b1;

  // Minimum that is reported while nothing is stored.
  localparam logic signed [KEY_W-1:0] EMPTY_MIN = -32'sd1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_EXTRACT
  } cell_op_t;

  typedef struct packed {
    logic                    req_type;
    logic signed [KEY_W-1:0] key_value;
  } in_t;

  typedef struct packed {
    logic signed [KEY_W-1:0] min_value;
    logic                    queue_empty;
    logic [COUNT_OUT_W-1:0]  entry_count;
    status_t                 status;
  } out_t;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    cell_op_t                op;
    logic signed [KEY_W-1:0] key;
  } cell_cmd_t;

  // What a cell shows its neighbors.
  typedef struct packed {
    logic                    valid;
    logic                    keep;
    logic signed [KEY_W-1:0] key;
  } cell_data_t;

endpackage

`default_nettype wire

// ===== rtl/mpq_cell.sv =====
// One cell of the sorted chain: holds a single key and its valid bit.
`default_nettype none

module mpq_cell
  import mpq_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire cell_cmd_t  cmd,
  input  wire cell_data_t left_data,
  input  wire cell_data_t right_data,
  output cell_data_t      cell_data
);

  logic                    valid_r;
  logic                    valid_nxt;
  logic signed [KEY_W-1:0] key_r;
  logic signed [KEY_W-1:0] key_nxt;
  logic                    keep;

  // The cell keeps its key on an insert when that key is not larger than the new one.
  assign keep = valid_r && (key_r <= cmd.key);

  always_comb begin
    valid_nxt = valid_r;
    key_nxt   = key_r;
    case (cmd.op)
      CELL_INSERT: begin
        if (!keep) begin
          if (left_data.keep) begin
            valid_nxt = 1'b1;
            key_nxt   = cmd.key;
          end else begin
            valid_nxt = left_data.valid;
            key_nxt   = left_data.key;
          end
        end
      end
      CELL_EXTRACT: begin
        valid_nxt = right_data.valid;
        key_nxt   = right_data.key;
      end
      default: begin
        valid_nxt = valid_r;
        key_nxt   = key_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

  assign cell_data.valid = valid_r;
  assign cell_data.keep  = keep;
  assign cell_data.key   = key_r;

endmodule

`default_nettype wire

// ===== rtl/min_priority_queue.sv =====
// Top level of the bounded min-priority queue built as a sorted chain of cells.
`default_nettype none

// A request is taken when start is high and busy is low; busy then stays high for
// exactly one cycle, and no further request is taken until it falls. The cycle
// after the transfer the chain of CAPACITY cells updates in parallel: on an insert
// each cell compares its key with the new one and either holds, takes the new key
// or takes its left neighbor's key, and on an extract every cell takes its right
// neighbor's key. The result then sits on out_rsp for exactly one cycle, marked by
// out_valid, together with the cycle in which busy has fallen again; the receiver
// cannot stall it. The smallest key always lives in the first cell, so min_value
// is -1 and queue_empty is set when that cell is empty. An insert into a full
// queue is dropped with status 1, an extract from an empty queue leaves everything
// unchanged with status 2. entry_count shows the low five bits of the count.

module min_priority_queue
  import mpq_pkg::*;
#(
  parameter int CAPACITY = DEFAULT_CAPACITY
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  output logic      busy,
  input  wire in_t  in_req,
  output logic      out_valid,
  output out_t      out_rsp
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);

  logic             busy_r;
  in_t              req_r;
  logic             out_valid_r;
  status_t          status_r;
  status_t          status_nxt;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             accept;
  logic             full;
  logic             empty;
  cell_cmd_t        cmd;
  cell_data_t       cell_q [CAPACITY];
  cell_data_t       left_edge;
  cell_data_t       right_edge;

  assign accept = start && !busy_r;
  assign full   = (count_r == CNT_FULL);
  assign empty  = (count_r == '0);

  // Request register: the transfer lands here and the chain works on it next cycle.
  always_ff @(posedge clk) begin
    if (accept) begin
      req_r <= in_req;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      count_r     <= '0;
      status_r    <= ST_OK;
    end else begin
      busy_r      <= accept;
      out_valid_r <= busy_r;
      if (busy_r) begin
        count_r  <= count_nxt;
        status_r <= status_nxt;
      end
    end
  end

  // Decide what the chain does with the pending request.
  always_comb begin
    cmd.op     = CELL_HOLD;
    cmd.key    = req_r.key_value;
    count_nxt  = count_r;
    status_nxt = ST_OK;
    if (busy_r) begin
      if (req_r.req_type == REQ_INSERT) begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          cmd.op    = CELL_INSERT;
          count_nxt = count_r + 1'b1;
        end
      end else begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          cmd.op    = CELL_EXTRACT;
          count_nxt = count_r - 1'b1;
        end
      end
    end
  end

  // The first cell sees a left neighbor that always keeps, so a new minimum lands
  // there; the last cell sees an empty right neighbor on an extract.
  assign left_edge.valid  = 1'b1;
  assign left_edge.keep   = 1'b1;
  assign left_edge.key    = '0;
  assign right_edge.valid = 1'b0;
  assign right_edge.keep  = 1'b0;
  assign right_edge.key   = '0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    mpq_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cmd        (cmd),
      .left_data  ((i == 0) ? left_edge : cell_q[(i == 0) ? 0 : i - 1]),
      .right_data ((i == CAPACITY - 1) ? right_edge
                                       : cell_q[(i == CAPACITY - 1) ? i : i + 1]),
      .cell_data  (cell_q[i])
    );
  end

  assign busy      = busy_r;
  assign out_valid = out_valid_r;

  assign out_rsp.min_value   = cell_q[0].valid ? cell_q[0].key : EMPTY_MIN;
  assign out_rsp.queue_empty = empty;
  assign out_rsp.entry_count = COUNT_OUT_W'(count_r);
  assign out_rsp.status      = status_r;

`ifndef SYNTHESIS
  // After every transfer, busy is high for exactly one cycle.
  a_busy_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |=> !busy_r)
    else $error("busy held for more than one cycle");

  // The count and the occupancy of the first cell must agree.
  a_count_matches_chain: assert property (@(posedge clk) disable iff (!rst_n)
    empty == !cell_q[0].valid)
    else $error("entry count disagrees with the chain");

  // The front of the chain stays sorted and packed.
  a_front_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    cell_q[1].valid |-> (cell_q[0].valid && (cell_q[0].key <= cell_q[1].key)))
    else $error("chain front out of order");

  // A dropped insert is reported only when the queue is full.
  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (status_r == ST_FULL)) |-> full)
    else $error("full status without a full queue");
`endif

endmodule

`default_nettype wire

// ===== test/min_priority_queue_tb.sv =====
// Self-checking testbench for the min-priority queue: directed cases, then random traffic.
`timescale 1ns / 1ps

module min_priority_queue_tb
  import mpq_pkg::*;
();

  // The block is built at its default size, and the scoreboard model uses the same bound.
  localparam int CAPACITY    = DEFAULT_CAPACITY;
  // A correct run ends well before this bound, so it leaves a wide margin.
  localparam int CYCLE_LIMIT = 200000;
  localparam int MAX_REPORTS = 10;
  // After the last result, keep the clock running in case a stray strobe follows.
  localparam int DRAIN_CYCLES = 8;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  in_t  in_req;
  logic out_valid;
  out_t out_rsp;

  // Keys the queue should hold right now. Their order is irrelevant, because only
  // the multiset of keys is visible at the outputs.
  logic signed [KEY_W-1:0] held_keys[$];
  // Responses that have been predicted and not yet seen, oldest first.
  out_t pending_rsp[$];

  int error_count    = 0;
  int cycle_count    = 0;
  // When this is set, the sender issues requests back to back with no gaps.
  bit no_idle        = 1'b0;

  min_priority_queue #(
    .CAPACITY(CAPACITY)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_req   (in_req),
    .out_valid(out_valid),
    .out_rsp  (out_rsp)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // The watchdog ends the run if the block stops answering.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Apply one request to the queue model and return the response it should cause.
  // An insert into a full queue and an extract from an empty one leave the model
  // unchanged and only set the status.
  function automatic out_t next_response(in_t req);
    out_t rsp;
    int   min_idx;
    rsp.status = ST_OK;
    if (req.req_type == REQ_INSERT) begin
      if (held_keys.size() >= CAPACITY) begin
        rsp.status = ST_FULL;
      end else begin
        held_keys = {held_keys, req.key_value};
      end
    end else begin
      if (held_keys.size() == 0) begin
        rsp.status = ST_EMPTY;
      end else begin
        // With equal minima any copy may go, since the multiset is the same.
        min_idx = 0;
        foreach (held_keys[i]) begin
          if (held_keys[i] < held_keys[min_idx]) begin
            min_idx = i;
          end
        end
        held_keys.delete(min_idx);
      end
    end
    // The reported minimum is -1 when nothing is stored; queue_empty separates
    // that case from a stored key of -1.
    rsp.min_value = EMPTY_MIN;
    foreach (held_keys[i]) begin
      if (i == 0 || held_keys[i] < rsp.min_value) begin
        rsp.min_value = held_keys[i];
      end
    end
    rsp.queue_empty = (held_keys.size() == 0);
    rsp.entry_count = COUNT_OUT_W'(held_keys.size());
    return rsp;
  endfunction

  // Send one request. Random gaps come first, unless gaps are switched off. The
  // transfer happens at the first rising edge with start high and busy low; the
  // expected response is recorded at that same edge. Start is left high, so the
  // next call either follows straight on or lowers it for a gap, which keeps one
  // assignment to start per time step.
  task automatic send_request(input logic req, input logic signed [KEY_W-1:0] key);
    in_t item;
    item.req_type  = req;
    item.key_value = key;
    if (!no_idle) begin
      while ($urandom_range(99) < 19) begin
        start <= 1'b0;
        @(posedge clk);
      end
    end
    start  <= 1'b1;
    in_req <= item;
    @(posedge clk);
    while (busy) begin
      @(posedge clk);
    end
    pending_rsp = {pending_rsp, next_response(item)};
  endtask

  // Keys are drawn so that extremes, -1 and duplicates show up often, while full-range
  // values make every key bit take both values.
  function automatic logic signed [KEY_W-1:0] random_key();
    case ($urandom_range(9))
      0: return {1'b1, {(KEY_W-1){1'b0}}};
      1: return {1'b0, {(KEY_W-1){1'b1}}};
      2: return -32'sd1;
      3: return 32'sd0;
      4, 5: return $signed(KEY_W'($urandom_range(7))) - 32'sd4;
      default: return $signed(KEY_W'($urandom()));
    endcase
  endfunction

  // The result checker takes every strobed result and compares it with the oldest
  // prediction. Results only exist for one cycle, so they are sampled at the edge
  // that ends that cycle.
  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid) begin
      if (pending_rsp.size() == 0) begin
        error_count <= error_count + 1;
        if (error_count < MAX_REPORTS) begin
          $display("Unexpected result: min %0d empty %0b count %0d status %0d",
                   out_rsp.min_value, out_rsp.queue_empty, out_rsp.entry_count,
                   out_rsp.status);
        end
      end else begin
        want = pending_rsp.pop_front();
        if (out_rsp.min_value !== want.min_value || out_rsp.queue_empty !== want.queue_empty
            || out_rsp.entry_count !== want.entry_count || out_rsp.status !== want.status)
        begin
          error_count <= error_count + 1;
          if (error_count < MAX_REPORTS) begin
            $display("Mismatch: expected min %0d empty %0b count %0d status %0d",
                     want.min_value, want.queue_empty, want.entry_count, want.status);
            $display("          actual   min %0d empty %0b count %0d status %0d",
                     out_rsp.min_value, out_rsp.queue_empty, out_rsp.entry_count,
                     out_rsp.status);
          end
        end
      end
    end
  end

  // Extracts from an empty queue must leave it empty and report the empty status.
  task automatic test_extract_empty();
    send_request(REQ_EXTRACT, 32'sd0);
    send_request(REQ_EXTRACT, -32'sd1);
  endtask

  // The most negative and most positive keys, zero, and -1 stored twice. While -1
  // is the minimum, min_value reads -1 with queue_empty low. Draining frees the
  // duplicates one at a time.
  task automatic test_key_extremes();
    send_request(REQ_INSERT, {1'b0, {(KEY_W-1){1'b1}}});
    send_request(REQ_INSERT, -32'sd1);
    send_request(REQ_INSERT, -32'sd1);
    send_request(REQ_INSERT, 32'sd0);
    send_request(REQ_INSERT, {1'b1, {(KEY_W-1){1'b0}}});
    repeat (5) begin
      send_request(REQ_EXTRACT, $signed(KEY_W'($urandom())));
    end
    send_request(REQ_EXTRACT, 32'sd5);
  endtask

  // Fill the queue to capacity, then insert twice more. Both extra keys must be
  // dropped with the full status and must not disturb the stored ones.
  task automatic test_full_queue();
    repeat (CAPACITY) begin
      send_request(REQ_INSERT, random_key());
    end
    send_request(REQ_INSERT, {1'b1, {(KEY_W-1){1'b0}}});
    send_request(REQ_INSERT, random_key());
  endtask

  // Random mix of inserts and extracts. The insert share is chosen per phase so
  // that the fill level sweeps between empty and full, and each boundary is hit
  // many times.
  task automatic test_random_traffic(input int count, input int insert_pct);
    repeat (count) begin
      if ($urandom_range(99) < insert_pct) begin
        send_request(REQ_INSERT, random_key());
      end else begin
        send_request(REQ_EXTRACT, $signed(KEY_W'($urandom())));
      end
    end
  endtask

  initial begin
    rst_n  <= 1'b0;
    start  <= 1'b0;
    in_req <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    test_extract_empty();
    test_key_extremes();
    test_full_queue();

    test_random_traffic(250, 30);
    test_random_traffic(250, 70);
    // A long stretch with requests issued back to back.
    no_idle = 1'b1;
    test_random_traffic(250, 50);
    no_idle = 1'b0;
    test_random_traffic(100, 75);
    test_random_traffic(100, 25);

    start <= 1'b0;
    // Every transfer must be matched by exactly one result.
    while (pending_rsp.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
